FILE: rtl/tdp_pkg.sv
package tdp_pkg;

    // Register indexes on the configuration port (byte address / 4)
    localparam logic [1:0] REG_ISN = 2'd0;
    localparam logic [1:0] REG_WIN = 2'd1;
    localparam logic [1:0] REG_MSS = 2'd2;

    localparam logic [31:0] ISN_RESET = 32'd123456;
    localparam logic [15:0] WIN_RESET = 16'd65000;
    localparam logic [15:0] MSS_RESET = 16'd1000;

    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [7:0]  IP_VER_IHL   = 8'h45;
    localparam logic [15:0] MSS_OPT_WORD = 16'h0204;

    // Received flag bits
    localparam int IN_FIN_BIT = 0;
    localparam int IN_SYN_BIT = 1;

    // Reply flag codes
    localparam logic [2:0] OUT_FIN = 3'b001;
    localparam logic [2:0] OUT_SYN = 3'b010;
    localparam logic [2:0] OUT_ACK = 3'b100;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_FIN,
        KIND_SYN
    } tdp_kind_t;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] seq_num;
        logic [3:0]  ip_hdr_words;
        logic [15:0] total_len;
        logic [3:0]  data_offset;
        logic [47:0] ip_copied;
    } tdp_in_t;

    // One classified request waiting for the checksum back end
    typedef struct packed {
        logic [31:0] reply_src_addr;
        logic [31:0] reply_dst_addr;
        logic [15:0] reply_src_port;
        logic [15:0] reply_dst_port;
        logic [31:0] reply_seq;
        logic [31:0] reply_ack;
        logic [2:0]  reply_flags;
        logic        mss_opt;
        logic [47:0] ip_copied;
    } tdp_entry_t;

    typedef struct packed {
        logic [31:0] reply_src_addr;
        logic [31:0] reply_dst_addr;
        logic [15:0] reply_src_port;
        logic [15:0] reply_dst_port;
        logic [31:0] reply_seq;
        logic [31:0] reply_ack;
        logic [2:0]  reply_flags;
        logic [2:0]  reply_offset;
        logic [5:0]  reply_total_len;
        logic [15:0] ip_checksum;
        logic [15:0] tcp_checksum;
    } tdp_reply_t;

endpackage

FILE: rtl/tdp_front.sv
module tdp_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  tdp_pkg::tdp_in_t    in_item,
    input  logic [1:0]          in_flags,
    input  logic [31:0]         isn,
    output logic                push_valid,
    input  logic                push_ready,
    output tdp_pkg::tdp_entry_t push_entry
);
    import tdp_pkg::*;

    logic [5:0]  ihl4;
    logic [5:0]  doff4;
    logic        too_short;
    logic [15:0] paylen;
    logic        want_reply;
    tdp_kind_t   kind;

    logic        f1_valid_reg, f1_valid_next;
    tdp_in_t     f1_item_reg, f1_item_next;
    tdp_kind_t   f1_kind_reg, f1_kind_next;
    logic [15:0] f1_paylen_reg, f1_paylen_next;

    // Classify the incoming segment
    always_comb begin
        ihl4      = {in_item.ip_hdr_words, 2'b00};
        doff4     = {in_item.data_offset, 2'b00};
        too_short = (17'(in_item.total_len) < 17'(ihl4) + 17'd20) ||
                    (17'(in_item.total_len) < 17'(ihl4) + 17'(doff4));
        paylen    = in_item.total_len - 16'(ihl4) - 16'(doff4);
        if (in_flags[IN_SYN_BIT]) begin
            kind = KIND_SYN;
        end else if (in_flags[IN_FIN_BIT]) begin
            kind = KIND_FIN;
        end else begin
            kind = KIND_DATA;
        end
        want_reply = !too_short && ((kind != KIND_DATA) || (paylen != 16'd0));
    end

    assign in_ready = !f1_valid_reg || push_ready;

    always_comb begin
        f1_valid_next  = f1_valid_reg;
        f1_item_next   = f1_item_reg;
        f1_kind_next   = f1_kind_reg;
        f1_paylen_next = f1_paylen_reg;
        if (in_ready) begin
            // drop segments that get no reply right here
            f1_valid_next = in_valid && want_reply;
        end
        if (in_ready && in_valid) begin
            f1_item_next   = in_item;
            f1_kind_next   = kind;
            f1_paylen_next = paylen;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
        end else begin
            f1_valid_reg <= f1_valid_next;
        end
        f1_item_reg   <= f1_item_next;
        f1_kind_reg   <= f1_kind_next;
        f1_paylen_reg <= f1_paylen_next;
    end

    // Build the reply entry: swapped addresses and ports, flags, MSS option, sequence and acknowledgement numbers
    always_comb begin
        push_entry.reply_src_addr = f1_item_reg.dst_addr;
        push_entry.reply_dst_addr = f1_item_reg.src_addr;
        push_entry.reply_src_port = f1_item_reg.dst_port;
        push_entry.reply_dst_port = f1_item_reg.src_port;
        push_entry.ip_copied      = f1_item_reg.ip_copied;
        case (f1_kind_reg)
            KIND_SYN: begin
                push_entry.reply_seq   = isn;
                push_entry.reply_ack   = f1_item_reg.seq_num + 32'd1;
                push_entry.reply_flags = OUT_SYN | OUT_ACK;
                push_entry.mss_opt     = 1'b1;
            end
            KIND_FIN: begin
                push_entry.reply_seq   = isn + 32'd1;
                push_entry.reply_ack   = f1_item_reg.seq_num + 32'd1;
                push_entry.reply_flags = OUT_FIN | OUT_ACK;
                push_entry.mss_opt     = 1'b0;
            end
            default: begin
                push_entry.reply_seq   = isn + 32'd1;
                push_entry.reply_ack   = f1_item_reg.seq_num + 32'(f1_paylen_reg);
                push_entry.reply_flags = OUT_ACK;
                push_entry.mss_opt     = 1'b0;
            end
        endcase
    end

    assign push_valid = f1_valid_reg;

endmodule

FILE: rtl/tdp_queue.sv
module tdp_queue #(
    parameter int DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  tdp_pkg::tdp_entry_t push_entry,
    output logic                pop_valid,
    input  logic                pop_ready,
    output tdp_pkg::tdp_entry_t pop_entry
);
    import tdp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tdp_entry_t     slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: rtl/tdp_back.sv
module tdp_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  tdp_pkg::tdp_entry_t pop_entry,
    input  logic [15:0]         window,
    input  logic [15:0]         mss,
    output logic                out_valid,
    input  logic                out_ready,
    output tdp_pkg::tdp_reply_t out_reply
);
    import tdp_pkg::*;

    logic        b1_adv, b2_adv;
    logic [5:0]  rlen;
    logic [15:0] tcplen;
    logic [2:0]  roff;
    logic [7:0]  hdrflags;
    logic [15:0] hdrword;
    logic [7:0]  tos, ttl;
    logic [15:0] ident, frag;

    logic        b1_valid_reg, b1_valid_next;
    tdp_entry_t  b1_entry_reg, b1_entry_next;
    logic [18:0] b1_ip_reg, b1_ip_next;
    logic [18:0] b1_addr_reg, b1_addr_next;
    logic [18:0] b1_tcpa_reg, b1_tcpa_next;
    logic [18:0] b1_tcpb_reg, b1_tcpb_next;

    logic [20:0] ip_acc, tcp_acc;
    logic [16:0] ip_f1, tcp_f1;
    logic [15:0] ip_f2, tcp_f2;

    logic        b2_valid_reg, b2_valid_next;
    tdp_reply_t  b2_reply_reg, b2_reply_next;

    assign b2_adv    = !b2_valid_reg || out_ready;
    assign b1_adv    = !b1_valid_reg || b2_adv;
    assign pop_ready = b1_adv;

    // Stage one: partial one's complement sums
    always_comb begin
        rlen     = pop_entry.mss_opt ? 6'd44 : 6'd40;
        roff     = pop_entry.mss_opt ? 3'd6 : 3'd5;
        tcplen   = {11'd0, roff, 2'b00};
        hdrflags = {3'b000, pop_entry.reply_flags[2], 2'b00,
                    pop_entry.reply_flags[1], pop_entry.reply_flags[0]};
        hdrword  = {1'b0, roff, 4'b0000, hdrflags};
        tos      = pop_entry.ip_copied[47:40];
        ident    = pop_entry.ip_copied[39:24];
        frag     = pop_entry.ip_copied[23:8];
        ttl      = pop_entry.ip_copied[7:0];

        b1_ip_next   = 19'({IP_VER_IHL, tos}) + 19'(rlen) + 19'(ident) + 19'(frag)
                     + 19'({ttl, PROTO_TCP});
        b1_addr_next = 19'(pop_entry.reply_src_addr[31:16])
                     + 19'(pop_entry.reply_src_addr[15:0])
                     + 19'(pop_entry.reply_dst_addr[31:16])
                     + 19'(pop_entry.reply_dst_addr[15:0]);
        b1_tcpa_next = 19'(PROTO_TCP) + 19'(tcplen)
                     + 19'(pop_entry.reply_src_port) + 19'(pop_entry.reply_dst_port)
                     + 19'(pop_entry.reply_seq[31:16]) + 19'(pop_entry.reply_seq[15:0])
                     + 19'(pop_entry.reply_ack[31:16]) + 19'(pop_entry.reply_ack[15:0]);
        b1_tcpb_next = 19'(hdrword) + 19'(window)
                     + (pop_entry.mss_opt ? (19'(MSS_OPT_WORD) + 19'(mss)) : 19'd0);

        b1_entry_next = pop_entry;
        b1_valid_next = b1_adv ? pop_valid : b1_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg <= 1'b0;
        end else begin
            b1_valid_reg <= b1_valid_next;
        end
        if (b1_adv) begin
            b1_entry_reg <= b1_entry_next;
            b1_ip_reg    <= b1_ip_next;
            b1_addr_reg  <= b1_addr_next;
            b1_tcpa_reg  <= b1_tcpa_next;
            b1_tcpb_reg  <= b1_tcpb_next;
        end
    end

    // Stage two: combine, fold carries twice, invert
    always_comb begin
        ip_acc  = 21'(b1_ip_reg) + 21'(b1_addr_reg);
        tcp_acc = 21'(b1_tcpa_reg) + 21'(b1_tcpb_reg) + 21'(b1_addr_reg);
        ip_f1   = 17'(ip_acc[15:0]) + 17'(ip_acc[20:16]);
        tcp_f1  = 17'(tcp_acc[15:0]) + 17'(tcp_acc[20:16]);
        ip_f2   = ip_f1[15:0] + 16'(ip_f1[16]);
        tcp_f2  = tcp_f1[15:0] + 16'(tcp_f1[16]);

        b2_reply_next.reply_src_addr  = b1_entry_reg.reply_src_addr;
        b2_reply_next.reply_dst_addr  = b1_entry_reg.reply_dst_addr;
        b2_reply_next.reply_src_port  = b1_entry_reg.reply_src_port;
        b2_reply_next.reply_dst_port  = b1_entry_reg.reply_dst_port;
        b2_reply_next.reply_seq       = b1_entry_reg.reply_seq;
        b2_reply_next.reply_ack       = b1_entry_reg.reply_ack;
        b2_reply_next.reply_flags     = b1_entry_reg.reply_flags;
        b2_reply_next.reply_offset    = b1_entry_reg.mss_opt ? 3'd6 : 3'd5;
        b2_reply_next.reply_total_len = b1_entry_reg.mss_opt ? 6'd44 : 6'd40;
        b2_reply_next.ip_checksum     = ~ip_f2;
        b2_reply_next.tcp_checksum    = ~tcp_f2;

        b2_valid_next = b2_adv ? b1_valid_reg : b2_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b2_valid_reg <= 1'b0;
        end else begin
            b2_valid_reg <= b2_valid_next;
        end
        if (b2_adv) begin
            b2_reply_reg <= b2_reply_next;
        end
    end

    assign out_valid = b2_valid_reg;
    assign out_reply = b2_reply_reg;

endmodule

FILE: rtl/tcp_discard_reply_builder_core.sv
// Channel   | Dir | Ports                          | Carries
// ----------+-----+--------------------------------+------------------------------------
// segment   | in  | s_tvalid s_tready s_tdata      | parsed IPv4/TCP header of one
//           |     | s_tuser                        | received segment (flags in tuser)
// reply     | out | m_tvalid m_tready m_tdata      | reply header with both checksums
//           |     | m_tuser                        | (reply flags in tuser)
// config    | in  | psel penable pwrite paddr      | ISN, window, MSS registers
//           |     | pwdata prdata pready           |
//
// One segment is taken per cycle while s_tready is high; an accepted request passes
// the classify register, queue, partial-sum stage and output register in turn.
// Requests that earn no reply are dropped in the classify stage and never
// reach the queue. Reset is synchronous on aresetn low: pipeline and queue
// empty, registers back to ISN 123456, window 65000, MSS 1000.
// A stall on m_tready fills the output stages first, then the queue
// (QUEUE_DEPTH entries), then the classify register; only then does s_tready fall.
module tcp_discard_reply_builder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] src_addr, [63:32] dst_addr, [79:64] src_port, [95:80] dst_port,
    // [127:96] seq_num, [131:128] ip_hdr_words, [147:132] total_len,
    // [151:148] data_offset, [199:152] ip_copied
    input  logic [199:0] s_tdata,
    // [1:0] seg_flags
    input  logic [1:0]   s_tuser,

    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] reply_src_addr, [63:32] reply_dst_addr, [79:64] reply_src_port,
    // [95:80] reply_dst_port, [127:96] reply_seq, [159:128] reply_ack,
    // [162:160] reply_offset, [168:163] reply_total_len, [184:169] ip_checksum,
    // [200:185] tcp_checksum, [207:201] zero
    output logic [207:0] m_tdata,
    // [2:0] reply_flags
    output logic [2:0]   m_tuser,

    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import tdp_pkg::*;

    logic [31:0] isn_reg, isn_next;
    logic [15:0] win_reg, win_next;
    logic [15:0] mss_reg, mss_next;
    logic        cfg_write;

    tdp_in_t     in_item;
    logic        push_valid, push_ready;
    tdp_entry_t  push_entry;
    logic        pop_valid, pop_ready;
    tdp_entry_t  pop_entry;
    tdp_reply_t  reply;

    // Configuration registers: write on the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        isn_next = isn_reg;
        win_next = win_reg;
        mss_next = mss_reg;
        if (cfg_write) begin
            case (paddr[3:2])
                REG_ISN: isn_next = pwdata;
                REG_WIN: win_next = pwdata[15:0];
                REG_MSS: mss_next = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            isn_reg <= ISN_RESET;
            win_reg <= WIN_RESET;
            mss_reg <= MSS_RESET;
        end else begin
            isn_reg <= isn_next;
            win_reg <= win_next;
            mss_reg <= mss_next;
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ISN: prdata = isn_reg;
            REG_WIN: prdata = {16'd0, win_reg};
            REG_MSS: prdata = {16'd0, mss_reg};
            default: prdata = 32'd0;
        endcase
    end

    // Unpack the segment request
    always_comb begin
        in_item.src_addr     = s_tdata[31:0];
        in_item.dst_addr     = s_tdata[63:32];
        in_item.src_port     = s_tdata[79:64];
        in_item.dst_port     = s_tdata[95:80];
        in_item.seq_num      = s_tdata[127:96];
        in_item.ip_hdr_words = s_tdata[131:128];
        in_item.total_len    = s_tdata[147:132];
        in_item.data_offset  = s_tdata[151:148];
        in_item.ip_copied    = s_tdata[199:152];
    end

    // Front end: length checks, reply kind, seq/ack arithmetic
    tdp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .in_flags   (s_tuser),
        .isn        (isn_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // Decouple classify from checksum so each side stalls on its own
    tdp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // Back end: IPv4 and TCP checksums, output register
    tdp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .window    (win_reg),
        .mss       (mss_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_reply (reply)
    );

    assign m_tdata = {7'd0,
                      reply.tcp_checksum,
                      reply.ip_checksum,
                      reply.reply_total_len,
                      reply.reply_offset,
                      reply.reply_ack,
                      reply.reply_seq,
                      reply.reply_dst_port,
                      reply.reply_src_port,
                      reply.reply_dst_addr,
                      reply.reply_src_addr};
    assign m_tuser = reply.reply_flags;

endmodule

FILE: rtl/tdp_checker.sv
module tdp_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [207:0] m_tdata,
    input logic [2:0]   m_tuser
);
    import tdp_pkg::*;

    // Hold a stalled reply
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("reply changed while stalled");

    // Drop all replies in the cycle after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("reply valid right after reset");

    // MSS option only on SYN-ACK, and lengths follow the offset
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tuser == (OUT_SYN | OUT_ACK)) && (m_tdata[162:160] == 3'd6)
                      && (m_tdata[168:163] == 6'd44))
                  || ((m_tuser[1] == 1'b0) && (m_tdata[162:160] == 3'd5)
                      && (m_tdata[168:163] == 6'd40)))
        else $error("offset or length does not match reply flags");

    // Every reply carries ACK and never both SYN and FIN
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[2] && !(m_tuser[1] && m_tuser[0]))
        else $error("bad reply flags");

endmodule

bind tcp_discard_reply_builder_core tdp_checker u_tdp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import tdp_pkg::*;

    // Flag bits as they sit in the TCP header on the wire
    localparam logic [15:0] WIRE_FIN = 16'h0001;
    localparam logic [15:0] WIRE_SYN = 16'h0002;
    localparam logic [15:0] WIRE_ACK = 16'h0010;

    localparam int RANDOM_PER_PHASE = 95;
    localparam int DRAIN_CYCLES     = 8;   // four-stage pipeline plus margin

    // Fill patterns for the non-length fields of directed requests
    typedef enum {FILL_ZERO, FILL_ONES, FILL_RAND} fill_t;

    typedef struct {
        bit [31:0] src_addr;
        bit [31:0] dst_addr;
        bit [15:0] src_port;
        bit [15:0] dst_port;
        bit [31:0] seq_num;
        bit [1:0]  seg_flags;
        bit [3:0]  ip_hdr_words;
        bit [15:0] total_len;
        bit [3:0]  data_offset;
        bit [47:0] ip_copied;
    } segment_t;

    typedef struct {
        bit [31:0] src_addr;
        bit [31:0] dst_addr;
        bit [15:0] src_port;
        bit [15:0] dst_port;
        bit [31:0] seq;
        bit [31:0] ack;
        bit [2:0]  flags;
        bit [2:0]  offset;
        bit [5:0]  total_len;
        bit [15:0] ip_csum;
        bit [15:0] tcp_csum;
    } reply_hdr_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // [31:0] src_addr, [63:32] dst_addr, [79:64] src_port, [95:80] dst_port,
    // [127:96] seq_num, [131:128] ip_hdr_words, [147:132] total_len,
    // [151:148] data_offset, [199:152] ip_copied
    logic [199:0] s_tdata  = '0;
    // [1:0] seg_flags
    logic [1:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // [31:0] reply_src_addr, [63:32] reply_dst_addr, [79:64] reply_src_port,
    // [95:80] reply_dst_port, [127:96] reply_seq, [159:128] reply_ack,
    // [162:160] reply_offset, [168:163] reply_total_len, [184:169] ip_checksum,
    // [200:185] tcp_checksum, [207:201] zero
    logic [207:0] m_tdata;
    // [2:0] reply_flags
    logic [2:0]   m_tuser;
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [3:0]   paddr    = '0;
    logic [31:0]  pwdata   = '0;
    logic [31:0]  prdata;
    logic         pready;

    // Shadow copy of the configuration registers, as the block holds them
    bit [31:0] isn_cfg = ISN_RESET;
    bit [15:0] win_cfg = WIN_RESET;
    bit [15:0] mss_cfg = MSS_RESET;

    segment_t   seg_q[$];        // requests waiting for the driver
    reply_hdr_t reply_exp[$];    // reply headers still owed by the block
    segment_t   seg_next;        // request the driver is presenting
    segment_t   seg_cur;         // request on the bus, seen by the predictor
    reply_hdr_t reply_new;
    reply_hdr_t reply_want;
    bit         seg_taken = 1'b0;
    int         pushed_cnt = 0;
    int         accepted_cnt = 0;
    int         replies_due = 0;
    int         replies_seen = 0;
    int         errors = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;

    tcp_discard_reply_builder_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 aclk = ~aclk;

    // Fold the end-around carries and complement: RFC 1071 one's complement sum
    function automatic bit [15:0] csum_fold(bit [31:0] acc);
        while (acc[31:16] != 0)
            acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
        return ~acc[15:0];
    endfunction

    // Work out the reply header for one received segment; return 0 when the
    // segment earns no reply.
    function automatic bit build_reply(input segment_t sg, output reply_hdr_t rp);
        int        seglen;
        int        paylen;
        bit [31:0] acc;
        bit [15:0] ctl_word;
        seglen = int'(sg.total_len) - 4 * int'(sg.ip_hdr_words);
        // Short segment: too small for a TCP header or for its own data offset
        if (seglen < 20 || seglen < 4 * int'(sg.data_offset))
            return 1'b0;
        paylen = seglen - 4 * int'(sg.data_offset);
        rp.offset = 3'd5;
        // SYN wins over FIN when both are set
        if (sg.seg_flags[IN_SYN_BIT]) begin
            rp.seq    = isn_cfg;
            rp.ack    = sg.seq_num + 32'd1;
            rp.flags  = OUT_SYN | OUT_ACK;
            rp.offset = 3'd6;
        end else if (sg.seg_flags[IN_FIN_BIT]) begin
            rp.seq   = isn_cfg + 32'd1;
            rp.ack   = sg.seq_num + 32'd1;
            rp.flags = OUT_FIN | OUT_ACK;
        end else if (paylen > 0) begin
            rp.seq   = isn_cfg + 32'd1;
            rp.ack   = sg.seq_num + 32'(paylen);
            rp.flags = OUT_ACK;
        end else begin
            return 1'b0;
        end
        rp.total_len = 6'(20 + 4 * int'(rp.offset));
        rp.src_addr  = sg.dst_addr;
        rp.dst_addr  = sg.src_addr;
        rp.src_port  = sg.dst_port;
        rp.dst_port  = sg.src_port;

        // IP header: version/IHL forced to 4/5, copied tos, ident, fragment, ttl
        acc = {16'h0, IP_VER_IHL, sg.ip_copied[47:40]};
        acc = acc + {26'h0, rp.total_len};
        acc = acc + {16'h0, sg.ip_copied[39:24]};
        acc = acc + {16'h0, sg.ip_copied[23:8]};
        acc = acc + {16'h0, sg.ip_copied[7:0], PROTO_TCP};
        acc = acc + sg.src_addr[31:16] + sg.src_addr[15:0];
        acc = acc + sg.dst_addr[31:16] + sg.dst_addr[15:0];
        rp.ip_csum = csum_fold(acc);

        // TCP: pseudo-header, then the reply header with urgent pointer zero
        ctl_word = {1'b0, rp.offset, 12'h000};
        if ((rp.flags & OUT_FIN) != 0) ctl_word = ctl_word | WIRE_FIN;
        if ((rp.flags & OUT_SYN) != 0) ctl_word = ctl_word | WIRE_SYN;
        if ((rp.flags & OUT_ACK) != 0) ctl_word = ctl_word | WIRE_ACK;
        acc = sg.src_addr[31:16] + sg.src_addr[15:0];
        acc = acc + sg.dst_addr[31:16] + sg.dst_addr[15:0];
        acc = acc + {24'h0, PROTO_TCP} + 4 * int'(rp.offset);
        acc = acc + sg.src_port + sg.dst_port;
        acc = acc + rp.seq[31:16] + rp.seq[15:0];
        acc = acc + rp.ack[31:16] + rp.ack[15:0];
        acc = acc + ctl_word + win_cfg;
        if (rp.offset == 3'd6)
            acc = acc + MSS_OPT_WORD + mss_cfg;
        rp.tcp_csum = csum_fold(acc);
        return 1'b1;
    endfunction

    function automatic void check_field(string name, bit [31:0] want, bit [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endfunction

    function automatic segment_t random_header();
        segment_t sg;
        sg.src_addr     = $urandom;
        sg.dst_addr     = $urandom;
        sg.src_port     = 16'($urandom);
        sg.dst_port     = 16'($urandom);
        sg.seq_num      = $urandom;
        sg.seg_flags    = 2'($urandom_range(3));
        sg.ip_hdr_words = 4'($urandom);
        sg.total_len    = 16'($urandom);
        sg.data_offset  = 4'($urandom);
        sg.ip_copied    = {16'($urandom), 32'($urandom)};
        return sg;
    endfunction

    function automatic segment_t directed_seg(bit [1:0] flags, bit [3:0] ihl, bit [3:0] doff,
                                              bit [15:0] tot, fill_t fill);
        segment_t sg;
        sg = random_header();
        if (fill == FILL_ZERO) begin
            sg.src_addr = '0; sg.dst_addr = '0; sg.src_port = '0; sg.dst_port = '0;
            sg.seq_num  = '0; sg.ip_copied = '0;
        end else if (fill == FILL_ONES) begin
            sg.src_addr = '1; sg.dst_addr = '1; sg.src_port = '1; sg.dst_port = '1;
            sg.seq_num  = '1; sg.ip_copied = '1;
        end
        sg.seg_flags    = flags;
        sg.ip_hdr_words = ihl;
        sg.data_offset  = doff;
        sg.total_len    = tot;
        return sg;
    endfunction

    // Mostly well-formed segments with random content, some cut short, some noise
    function automatic segment_t shaped_seg();
        segment_t sg;
        int       shape;
        int       hdr;
        int       limit;
        sg = random_header();
        shape = $urandom_range(99);
        if (shape < 75) begin
            sg.ip_hdr_words = ($urandom_range(3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
            sg.data_offset  = ($urandom_range(3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
            hdr = 4 * (int'(sg.ip_hdr_words) + int'(sg.data_offset));
            if (shape < 5)
                sg.total_len = 16'($urandom_range(65535, hdr));
            else if ($urandom_range(1) == 0)
                sg.total_len = 16'(hdr);
            else
                sg.total_len = 16'(hdr + $urandom_range(1460, 1));
        end else if (shape < 90) begin
            limit = 4 * int'(sg.ip_hdr_words)
                  + ((sg.data_offset > 5) ? 4 * int'(sg.data_offset) : 20);
            sg.total_len = 16'($urandom_range(limit - 1, 0));
        end
        return sg;
    endfunction

    task automatic queue_seg(segment_t sg);
        seg_q.push_back(sg);
        pushed_cnt++;
    endtask

    // Hold until every request is in and every reply is out, then let the
    // pipeline run dry before touching the registers.
    task automatic settle();
        while (accepted_cnt != pushed_cnt || reply_exp.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Two-phase register write: setup, then access until pready
    task automatic write_reg(logic [1:0] idx, bit [31:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ISN: isn_cfg = val;
            REG_WIN: win_cfg = val[15:0];
            REG_MSS: mss_cfg = val[15:0];
            default: ;
        endcase
    endtask

    // Driver: change inputs on the falling edge. Advance to the next request
    // only once the current one was taken; insert sender gaps at random and
    // toggle m_tready for receiver stalls.
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || seg_taken)) begin
            if (seg_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                seg_next = seg_q.pop_front();
                seg_cur  <= seg_next;
                s_tdata  <= {seg_next.ip_copied, seg_next.data_offset, seg_next.total_len,
                             seg_next.ip_hdr_words, seg_next.seq_num, seg_next.dst_port,
                             seg_next.src_port, seg_next.dst_addr, seg_next.src_addr};
                s_tuser  <= seg_next.seg_flags;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: sample on the rising edge. Predict the reply of each taken
    // request, and check each delivered reply against the oldest one owed.
    always @(posedge aclk) begin
        if (!aresetn) begin
            seg_taken <= 1'b0;
        end else begin
            seg_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                accepted_cnt++;
                if (build_reply(seg_cur, reply_new)) begin
                    reply_exp.push_back(reply_new);
                    replies_due++;
                end
            end
            if (m_tvalid && m_tready) begin
                replies_seen++;
                if (reply_exp.size() == 0) begin
                    $error("reply delivered with none expected: tdata %0h", m_tdata);
                    errors++;
                end else begin
                    reply_want = reply_exp.pop_front();
                    check_field("reply_src_addr", reply_want.src_addr, m_tdata[31:0]);
                    check_field("reply_dst_addr", reply_want.dst_addr, m_tdata[63:32]);
                    check_field("reply_src_port", reply_want.src_port, m_tdata[79:64]);
                    check_field("reply_dst_port", reply_want.dst_port, m_tdata[95:80]);
                    check_field("reply_seq", reply_want.seq, m_tdata[127:96]);
                    check_field("reply_ack", reply_want.ack, m_tdata[159:128]);
                    check_field("reply_offset", reply_want.offset, m_tdata[162:160]);
                    check_field("reply_total_len", reply_want.total_len, m_tdata[168:163]);
                    check_field("ip_checksum", reply_want.ip_csum, m_tdata[184:169]);
                    check_field("tcp_checksum", reply_want.tcp_csum, m_tdata[200:185]);
                    check_field("tdata padding", 32'h0, m_tdata[207:201]);
                    check_field("reply_flags", reply_want.flags, m_tuser);
                end
            end
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset register values; sender idles rarely, receiver stalls often
        send_idle_pct  = 12;
        recv_stall_pct = 72;
        queue_seg(directed_seg(2'b10, 4'd5, 4'd5, 16'd40, FILL_ZERO));     // bare SYN
        queue_seg(directed_seg(2'b10, 4'd5, 4'd5, 16'd40, FILL_ONES));     // SYN, ack wraps
        queue_seg(directed_seg(2'b01, 4'd5, 4'd5, 16'd40, FILL_ONES));     // FIN, ack wraps
        queue_seg(directed_seg(2'b01, 4'd5, 4'd5, 16'd40, FILL_ZERO));
        queue_seg(directed_seg(2'b11, 4'd5, 4'd5, 16'd40, FILL_RAND));     // SYN over FIN
        queue_seg(directed_seg(2'b00, 4'd5, 4'd5, 16'd41, FILL_RAND));     // one payload byte
        queue_seg(directed_seg(2'b00, 4'd5, 4'd5, 16'hFFFF, FILL_ONES));   // largest payload
        queue_seg(directed_seg(2'b00, 4'd5, 4'd5, 16'd40, FILL_RAND));     // no flags, no data
        queue_seg(directed_seg(2'b10, 4'd5, 4'd5, 16'd39, FILL_RAND));     // one byte short
        queue_seg(directed_seg(2'b10, 4'd5, 4'd6, 16'd40, FILL_RAND));     // short of offset
        queue_seg(directed_seg(2'b10, 4'd15, 4'd15, 16'd120, FILL_RAND));  // exact fit
        queue_seg(directed_seg(2'b01, 4'd15, 4'd15, 16'd119, FILL_RAND));  // one under
        queue_seg(directed_seg(2'b00, 4'd15, 4'd15, 16'hFFFF, FILL_RAND));
        queue_seg(directed_seg(2'b01, 4'd0, 4'd0, 16'd20, FILL_RAND));     // zero IHL and offset
        queue_seg(directed_seg(2'b00, 4'd0, 4'd0, 16'd21, FILL_RAND));
        queue_seg(directed_seg(2'b01, 4'd0, 4'd0, 16'd19, FILL_RAND));
        queue_seg(directed_seg(2'b11, 4'd0, 4'd0, 16'd0, FILL_ONES));      // empty packet
        queue_seg(directed_seg(2'b00, 4'd4, 4'd3, 16'd40, FILL_RAND));     // small offsets, data
        queue_seg(directed_seg(2'b01, 4'd5, 4'd15, 16'd80, FILL_ZERO));    // FIN, full options
        repeat (RANDOM_PER_PHASE) queue_seg(shaped_seg());
        settle();

        // Top extremes: ISN+1 wraps to zero; swap the idle pattern
        write_reg(REG_ISN, 32'hFFFF_FFFF);
        write_reg(REG_WIN, 32'h0000_0000);
        write_reg(REG_MSS, 32'h0000_FFFF);
        send_idle_pct  = 72;
        recv_stall_pct = 12;
        repeat (RANDOM_PER_PHASE) queue_seg(shaped_seg());
        settle();

        // Bottom extremes, full rate on both sides
        write_reg(REG_ISN, 32'h0000_0000);
        write_reg(REG_WIN, 32'h0000_FFFF);
        write_reg(REG_MSS, 32'h0000_0000);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (RANDOM_PER_PHASE) queue_seg(shaped_seg());
        settle();

        // Random register values
        write_reg(REG_ISN, $urandom);
        write_reg(REG_WIN, {16'h0, 16'($urandom)});
        write_reg(REG_MSS, {16'h0, 16'($urandom)});
        repeat (RANDOM_PER_PHASE) queue_seg(shaped_seg());
        settle();

        if (reply_exp.size() != 0) begin
            $error("%0d replies never delivered", reply_exp.size());
            errors++;
        end
        $display("Ran %0d segments through four register settings and three idle patterns;",
                 accepted_cnt);
        $display("%0d replies checked, %0d segments correctly left unanswered, %0d mismatches.",
                 replies_seen, accepted_cnt - replies_due, errors);
        if (errors == 0) begin
            $display("[tcp_discard_reply_builder_core] OK");
        end else begin
            $display("[tcp_discard_reply_builder_core] ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("Timed out waiting for requests or replies");
        $display("[tcp_discard_reply_builder_core] ERROR");
        $finish;
    end

endmodule

FILE: tcp_discard_reply_builder_core.f
rtl/tdp_pkg.sv
rtl/tdp_front.sv
rtl/tdp_queue.sv
rtl/tdp_back.sv
rtl/tcp_discard_reply_builder_core.sv
rtl/tdp_checker.sv
test/tb_top.sv
